FILE: rtl/core/cdsdr_pkg.sv
`default_nettype none

package cdsdr_pkg;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic [1:0] {
        OP_SET_CURSOR = 2'd0,
        OP_PUT_CHAR   = 2'd1,
        OP_WIPE_LINE  = 2'd2,
        OP_FLUSH      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_WIPE  = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_FINISH
    } t_bstate;

endpackage

`default_nettype wire

FILE: rtl/core/cdsdr_cmd_q.sv
`default_nettype none

module cdsdr_cmd_q #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

FILE: rtl/core/cdsdr_front.sv
`default_nettype none

module cdsdr_front #(
    parameter int COLS = 16,
    parameter int ROWS = 2,
    parameter int CW   = 4,
    parameter int RW   = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_operation,
    input  wire logic [5:0]    i_column,
    input  wire logic [2:0]    i_row,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_q_full,
    output logic               o_push,
    output cdsdr_pkg::t_cmd_kind o_kind,
    output logic [RW-1:0]      o_row,
    output logic [CW-1:0]      o_col,
    output logic [7:0]         o_char
);

    import cdsdr_pkg::*;

    logic          r_past;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          n_past;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          accept;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_char  = i_char_code;

    always_comb begin
        n_past = r_past;
        n_col  = r_col;
        n_row  = r_row;
        o_push = 1'b0;
        o_kind = CMD_FLUSH;
        unique case (t_op'(i_operation))
            OP_SET_CURSOR: begin
                n_past = 1'b0;
                n_col  = (i_column >= 6'(COLS)) ? CW'(COLS - 1) : CW'(i_column);
                n_row  = (i_row >= 3'(ROWS)) ? RW'(ROWS - 1) : RW'(i_row);
            end
            OP_PUT_CHAR: begin
                o_kind = CMD_WRITE;
                o_push = accept && !r_past;
                if (!r_past) begin
                    if (r_col == CW'(COLS - 1)) begin
                        if (r_row == RW'(ROWS - 1)) begin
                            n_past = 1'b1;
                        end else begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            OP_WIPE_LINE: begin
                o_kind = CMD_WIPE;
                o_push = accept && !r_past;
            end
            OP_FLUSH: begin
                o_kind = CMD_FLUSH;
                o_push = accept;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_past <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (accept) begin
            r_past <= n_past;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cdsdr_back.sv
`default_nettype none

module cdsdr_back #(
    parameter int COLS = 16,
    parameter int ROWS = 2,
    parameter int CW   = 4,
    parameter int RW   = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire cdsdr_pkg::t_cmd_kind i_cmd_kind,
    input  wire logic [RW-1:0] i_cmd_row,
    input  wire logic [CW-1:0] i_cmd_col,
    input  wire logic [7:0]    i_cmd_char,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_cell_valid,
    output logic               o_move_cursor,
    output logic [3:0]         o_out_column,
    output logic               o_out_row,
    output logic [7:0]         o_out_char,
    output logic               o_last
);

    import cdsdr_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    t_bstate       r_state;
    t_bstate       n_state;

    logic [7:0]    r_screen_mem [CELLS];
    logic [7:0]    r_shown_mem  [CELLS];
    logic [CELLS-1:0] r_scr_vld;
    logic [CELLS-1:0] r_shw_vld;

    logic [CW-1:0] r_sc;
    logic [RW-1:0] r_sr;
    logic          r_issue_pend;
    logic          r_rd_valid;
    logic [CW-1:0] r_rd_c;
    logic [RW-1:0] r_rd_r;
    logic          r_rd_last;
    logic [7:0]    r_scr_q;
    logic [7:0]    r_shw_q;
    logic          r_scr_ok;
    logic          r_shw_ok;

    logic          r_known;
    logic [CW-1:0] r_disp_col;
    logic [RW-1:0] r_disp_row;

    logic          r_hold_valid;
    logic          r_hold_move;
    logic [CW-1:0] r_hold_col;
    logic [RW-1:0] r_hold_row;
    logic [7:0]    r_hold_char;

    logic          r_out_valid;
    logic          r_out_cell_valid;
    logic          r_out_move;
    logic [3:0]    r_out_col;
    logic          r_out_row;
    logic [7:0]    r_out_char;
    logic          r_out_last;

    logic          scr_we;
    logic          wipe_en;
    logic          flush_start;
    logic          rd_en;
    logic          eval;
    logic          fin;
    logic          out_free;
    logic          differ;
    logic          adv;
    logic          follows;
    logic          take;
    logic [7:0]    scr_eff;
    logic [7:0]    shw_eff;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] ev_idx;

    assign wr_idx   = AW'(int'(i_cmd_row) * COLS + int'(i_cmd_col));
    assign rd_idx   = AW'(int'(r_sr) * COLS + int'(r_sc));
    assign ev_idx   = AW'(int'(r_rd_r) * COLS + int'(r_rd_c));
    assign scr_eff  = r_scr_ok ? r_scr_q : SPACE_CHAR;
    assign shw_eff  = r_shw_ok ? r_shw_q : SPACE_CHAR;
    assign differ   = r_rd_valid && (scr_eff != shw_eff);
    assign out_free = !r_out_valid || !i_stall;
    assign adv      = !r_rd_valid || !differ || !r_hold_valid || out_free;
    assign follows  = r_known && (r_disp_row == r_rd_r)
                      && (({1'b0, r_disp_col} + 1'b1) == {1'b0, r_rd_c});
    assign take     = eval && differ;

    always_comb begin
        n_state     = r_state;
        o_cmd_pop   = 1'b0;
        scr_we      = 1'b0;
        wipe_en     = 1'b0;
        flush_start = 1'b0;
        rd_en       = 1'b0;
        eval        = 1'b0;
        fin         = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd_kind)
                        CMD_WRITE: scr_we = 1'b1;
                        CMD_WIPE:  wipe_en = 1'b1;
                        CMD_FLUSH: begin
                            flush_start = 1'b1;
                            n_state     = BS_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            BS_SCAN: begin
                rd_en = r_issue_pend && adv;
                eval  = r_rd_valid && adv;
                if (eval && r_rd_last) begin
                    n_state = BS_FINISH;
                end
            end
            BS_FINISH: begin
                if (out_free) begin
                    fin     = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_screen_mem[wr_idx] <= i_cmd_char;
        end
        if (rd_en) begin
            r_scr_q <= r_screen_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_shown_mem[ev_idx] <= scr_eff;
        end
        if (rd_en) begin
            r_shw_q <= r_shown_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_vld <= '0;
            r_shw_vld <= '0;
        end else begin
            if (scr_we) begin
                r_scr_vld[wr_idx] <= 1'b1;
            end
            if (wipe_en) begin
                for (int i = 0; i < CELLS; i++) begin
                    if ((i / COLS) == int'(i_cmd_row) && (i % COLS) >= int'(i_cmd_col)) begin
                        r_scr_vld[i] <= 1'b0;
                    end
                end
            end
            if (take) begin
                r_shw_vld[ev_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc         <= '0;
            r_sr         <= '0;
            r_issue_pend <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_known      <= 1'b0;
            r_disp_col   <= '0;
            r_disp_row   <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (flush_start) begin
                r_sc         <= '0;
                r_sr         <= '0;
                r_issue_pend <= 1'b1;
                r_rd_valid   <= 1'b0;
            end else if (rd_en) begin
                r_rd_valid <= 1'b1;
                if (r_sr == RW'(ROWS - 1)) begin
                    r_sr <= '0;
                    if (r_sc == CW'(COLS - 1)) begin
                        r_issue_pend <= 1'b0;
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end else begin
                    r_sr <= r_sr + 1'b1;
                end
            end else if (eval) begin
                r_rd_valid <= 1'b0;
            end
            if (take) begin
                r_known      <= 1'b1;
                r_disp_col   <= r_rd_c;
                r_disp_row   <= r_rd_r;
                r_hold_valid <= 1'b1;
            end else if (fin) begin
                r_hold_valid <= 1'b0;
            end
            if ((take && r_hold_valid) || fin) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_c    <= r_sc;
            r_rd_r    <= r_sr;
            r_rd_last <= (r_sc == CW'(COLS - 1)) && (r_sr == RW'(ROWS - 1));
            r_scr_ok  <= r_scr_vld[rd_idx];
            r_shw_ok  <= r_shw_vld[rd_idx];
        end
        if (take) begin
            r_hold_move <= !follows;
            r_hold_col  <= r_rd_c;
            r_hold_row  <= r_rd_r;
            r_hold_char <= scr_eff;
        end
        if (take && r_hold_valid) begin
            r_out_cell_valid <= 1'b1;
            r_out_move       <= r_hold_move;
            r_out_col        <= 4'(r_hold_col);
            r_out_row        <= 1'(r_hold_row);
            r_out_char       <= r_hold_char;
            r_out_last       <= 1'b0;
        end else if (fin) begin
            r_out_cell_valid <= r_hold_valid;
            r_out_move       <= r_hold_valid && r_hold_move;
            r_out_col        <= r_hold_valid ? 4'(r_hold_col) : 4'd0;
            r_out_row        <= r_hold_valid ? 1'(r_hold_row) : 1'b0;
            r_out_char       <= r_hold_valid ? r_hold_char : 8'd0;
            r_out_last       <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cell_valid  = r_out_cell_valid;
    assign o_move_cursor = r_out_move;
    assign o_out_column  = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_out_char    = r_out_char;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/char_display_shadow_diff_refresh_top.sv
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_operation i_column i_row i_char_code
// result    out        o_valid / i_stall      o_cell_valid o_move_cursor o_out_column
//                                             o_out_row o_out_char o_last
//
// set cursor is handled in the front alone; put character and wipe line are each
// carried out in the back, and a wipe clears the rest of the row at once
// flush scans one cell per cycle through the image memories while the result
// side does not stall; a command queue of 4 sits between
// reset clears the per-cell valid flags of both images at once, no clearing pass
// the input stalls only while the command queue is full
`default_nettype none

module char_display_shadow_diff_refresh_top #(
    parameter int COLS = 16,
    parameter int ROWS = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [5:0] i_column,
    input  wire logic [2:0] i_row,
    input  wire logic [7:0] i_char_code,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_cell_valid,
    output logic            o_move_cursor,
    output logic [3:0]      o_out_column,
    output logic            o_out_row,
    output logic [7:0]      o_out_char,
    output logic            o_last
);

    import cdsdr_pkg::*;

    localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QDEPTH = 4;
    localparam int CMD_W  = 2 + RW + CW + 8;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;
    t_cmd_kind        fe_kind;
    logic [RW-1:0]    fe_row;
    logic [CW-1:0]    fe_col;
    logic [7:0]       fe_char;

    cdsdr_front #(
        .COLS (COLS),
        .ROWS (ROWS),
        .CW   (CW),
        .RW   (RW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_char_code (i_char_code),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_kind      (fe_kind),
        .o_row       (fe_row),
        .o_col       (fe_col),
        .o_char      (fe_char)
    );

    assign q_wdata = {fe_kind, fe_row, fe_col, fe_char};

    cdsdr_cmd_q #(
        .WIDTH (CMD_W),
        .DEPTH (QDEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cdsdr_back #(
        .COLS (COLS),
        .ROWS (ROWS),
        .CW   (CW),
        .RW   (RW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (!q_empty),
        .o_cmd_pop     (q_pop),
        .i_cmd_kind    (t_cmd_kind'(q_rdata[CMD_W-1 -: 2])),
        .i_cmd_row     (q_rdata[8+CW +: RW]),
        .i_cmd_col     (q_rdata[8 +: CW]),
        .i_cmd_char    (q_rdata[7:0]),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cell_valid  (o_cell_valid),
        .o_move_cursor (o_move_cursor),
        .o_out_column  (o_out_column),
        .o_out_row     (o_out_row),
        .o_out_char    (o_out_char),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cell_valid) |-> o_last)
        else $error("empty flush result without last");

    a_follow_not_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cell_valid && !o_move_cursor) |-> (o_out_column != 4'd0))
        else $error("cursor follow claimed at column zero");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

FILE: tb/char_display_shadow_diff_refresh_top_tb.sv
`timescale 1ns / 100ps

module char_display_shadow_diff_refresh_top_tb;

    import cdsdr_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int NCOLS = 16;
    localparam int NROWS = 2;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int ITEM_TARGET = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        logic       cell_valid;
        logic       move_cursor;
        logic [3:0] column;
        logic       row;
        logic [7:0] ch;
        logic       last;
    } t_cell_update;

    class refresh_scoreboard;
        logic [7:0]   screen[NCELLS];
        logic [7:0]   shown[NCELLS];
        int unsigned  print_pos;
        logic [3:0]   disp_col;
        logic         disp_row;
        bit           disp_known;
        t_cell_update expected_updates[$];
        int unsigned  mismatches;

        function new();
            foreach (screen[k]) begin
                screen[k] = SPACE_CHAR;
                shown[k] = SPACE_CHAR;
            end
            print_pos = 0;
            disp_col = '0;
            disp_row = 1'b0;
            disp_known = 1'b0;
            mismatches = 0;
        endfunction

        // apply one accepted item to the predicted images
        function void take_command(t_op op, logic [5:0] col, logic [2:0] row,
                                   logic [7:0] ch);
            int unsigned  c;
            int unsigned  r;
            int unsigned  idx;
            int unsigned  stop_at;
            t_cell_update u;
            case (op)
                OP_SET_CURSOR: begin
                    c = (col >= NCOLS) ? NCOLS - 1 : col;
                    r = (row >= NROWS) ? NROWS - 1 : row;
                    print_pos = r * NCOLS + c;
                end
                OP_PUT_CHAR: begin
                    if (print_pos < NCELLS) begin
                        screen[print_pos] = ch;
                        print_pos++;
                    end
                end
                OP_WIPE_LINE: begin
                    if (print_pos < NCELLS) begin
                        stop_at = (print_pos / NCOLS + 1) * NCOLS;
                        for (idx = print_pos; idx < stop_at; idx++)
                            screen[idx] = SPACE_CHAR;
                    end
                end
                default: begin
                    // column-major diff scan
                    u = '0;
                    for (c = 0; c < NCOLS; c++) begin
                        for (r = 0; r < NROWS; r++) begin
                            idx = r * NCOLS + c;
                            if (screen[idx] != shown[idx]) begin
                                u.cell_valid = 1'b1;
                                u.move_cursor = !(disp_known && disp_row == r[0] &&
                                                  int'(disp_col) + 1 == int'(c));
                                u.column = c[3:0];
                                u.row = r[0];
                                u.ch = screen[idx];
                                u.last = 1'b0;
                                shown[idx] = screen[idx];
                                disp_col = c[3:0];
                                disp_row = r[0];
                                disp_known = 1'b1;
                                expected_updates.push_back(u);
                            end
                        end
                    end
                    if (!u.cell_valid) begin
                        u.last = 1'b1;
                        expected_updates.push_back(u);
                    end else begin
                        expected_updates[expected_updates.size() - 1].last = 1'b1;
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_update(t_cell_update got);
            t_cell_update want;
            if (expected_updates.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_updates.pop_front();
            compare_field("cell_valid", want.cell_valid, got.cell_valid);
            compare_field("move_cursor", want.move_cursor, got.move_cursor);
            compare_field("out_column", want.column, got.column);
            compare_field("out_row", want.row, got.row);
            compare_field("out_char", want.ch, got.ch);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending_count();
            return expected_updates.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_operation = 2'd0;
    logic [5:0] i_column = 6'd0;
    logic [2:0] i_row = 3'd0;
    logic [7:0] i_char_code = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_cell_valid;
    logic       o_move_cursor;
    logic [3:0] o_out_column;
    logic       o_out_row;
    logic [7:0] o_out_char;
    logic       o_last;

    refresh_scoreboard cells_sb = new();
    int unsigned       items_sent = 0;
    bit                quiet_in = 1'b0;
    bit                quiet_out = 1'b0;
    bit                want_hold = 1'b0;
    int unsigned       hold_left = 0;

    char_display_shadow_diff_refresh_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_char_code  (i_char_code),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_valid (o_cell_valid),
        .o_move_cursor(o_move_cursor),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_out_char   (o_out_char),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic send_item(t_op op, logic [5:0] col, logic [2:0] row, logic [7:0] ch);
        int unsigned gap;
        if (!quiet_in && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_column <= col;
        i_row <= row;
        i_char_code <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cells_sb.take_command(op, col, row, ch);
        items_sent++;
    endtask

    // spaces often, so some writes leave a cell unchanged
    function automatic logic [7:0] pick_char();
        return ($urandom_range(0, 3) == 0) ? SPACE_CHAR : 8'($urandom);
    endfunction

    task automatic random_sequence();
        int unsigned pick;
        int unsigned burst;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_item(OP_SET_CURSOR, 6'($urandom_range(0, NCOLS - 1)),
                      3'($urandom_range(0, NROWS - 1)), 8'($urandom));
            burst = $urandom_range(1, 8);
            for (k = 0; k < burst; k++)
                send_item(OP_PUT_CHAR, 6'($urandom), 3'($urandom), pick_char());
        end else if (pick < 40) begin
            send_item(OP_SET_CURSOR, 6'($urandom), 3'($urandom), 8'($urandom));
        end else if (pick < 58) begin
            burst = $urandom_range(1, 20);
            for (k = 0; k < burst; k++)
                send_item(OP_PUT_CHAR, 6'($urandom), 3'($urandom), pick_char());
        end else if (pick < 68) begin
            send_item(OP_WIPE_LINE, 6'($urandom), 3'($urandom), 8'($urandom));
        end else if (pick < 85) begin
            send_item(OP_FLUSH, 6'($urandom), 3'($urandom), 8'($urandom));
        end else begin
            send_item(t_op'($urandom_range(0, 3)), 6'($urandom), 3'($urandom),
                      8'($urandom));
        end
    endtask

    // result side: check, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            cells_sb.check_update('{o_cell_valid, o_move_cursor, o_out_column,
                                    o_out_row, o_out_char, o_last});
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (want_hold) begin
            want_hold = 1'b0;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet_out && ($urandom_range(0, 99) < 22);
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("char_display_shadow_diff_refresh_top_tb failed");
        $finish;
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flush with nothing changed
        send_item(OP_FLUSH, 6'd0, 3'd0, 8'd0);
        // clamp to last cell, then overflow
        send_item(OP_SET_CURSOR, 6'd63, 3'd7, 8'hFF);
        send_item(OP_PUT_CHAR, 6'd63, 3'd7, 8'h41);
        send_item(OP_PUT_CHAR, 6'd0, 3'd0, 8'hFF);
        send_item(OP_WIPE_LINE, 6'd0, 3'd0, 8'h00);
        // row wrap and extreme codes
        send_item(OP_SET_CURSOR, 6'd14, 3'd0, 8'h00);
        send_item(OP_PUT_CHAR, 6'd0, 3'd0, 8'h00);
        send_item(OP_PUT_CHAR, 6'd63, 3'd7, 8'hFF);
        send_item(OP_PUT_CHAR, 6'd21, 3'd5, 8'h42);
        send_item(OP_FLUSH, 6'd63, 3'd7, 8'hFF);
        // wipe mid row
        send_item(OP_SET_CURSOR, 6'd3, 3'd1, 8'h55);
        send_item(OP_WIPE_LINE, 6'd42, 3'd2, 8'hAA);
        send_item(OP_SET_CURSOR, 6'd0, 3'd0, 8'd0);
        send_item(OP_PUT_CHAR, 6'd0, 3'd0, 8'h78);
        send_item(OP_PUT_CHAR, 6'd0, 3'd0, 8'h79);
        send_item(OP_FLUSH, 6'd0, 3'd0, 8'd0);
        // wipe from last column, and a whole row
        send_item(OP_SET_CURSOR, 6'd63, 3'd0, 8'd0);
        send_item(OP_WIPE_LINE, 6'd0, 3'd0, 8'd0);
        send_item(OP_SET_CURSOR, 6'd0, 3'd7, 8'd0);
        send_item(OP_WIPE_LINE, 6'd0, 3'd0, 8'd0);
        send_item(OP_FLUSH, 6'd0, 3'd0, 8'd0);
        send_item(OP_FLUSH, 6'd0, 3'd0, 8'd0);

        while (items_sent < ITEM_TARGET) begin
            quiet_in = (items_sent >= 110 && items_sent < 170);
            quiet_out = quiet_in;
            if (!hold_done && items_sent >= 200) begin
                // receiver holds off while items keep coming
                hold_done = 1'b1;
                want_hold = 1'b1;
                send_item(OP_FLUSH, 6'($urandom), 3'($urandom), 8'($urandom));
            end
            random_sequence();
        end
        i_valid <= 1'b0;

        while (cells_sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (cells_sb.mismatches == 0 && cells_sb.pending_count() == 0)
            $display("char_display_shadow_diff_refresh_top_tb passed");
        else
            $display("char_display_shadow_diff_refresh_top_tb failed");
        $finish;
    end

endmodule
